@@ sv/sps_pkg.sv @@
// Shared types, register codes, constants and helper functions for the sonar pan
// sector scanner. No dependencies; imported by every module of the block.
`default_nettype none

package sps_pkg;

	// Fixed sector geometry and limits
	localparam int unsigned SECTOR_COUNT = 3;
	localparam int unsigned TIME_BITS_DEF = 32;
	localparam logic [7:0] CENTER_ANGLE = 8'd90;
	localparam logic [7:0] MAX_ANGLE = 8'd180;
	localparam logic [8:0] RANGE_MIN = 9'd1;
	localparam logic [8:0] RANGE_MAX = 9'd500;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SONAR_ENABLE   = 3'd0,
		REG_AUTO_PAN       = 3'd1,
		REG_MANUAL_ANGLE   = 3'd2,
		REG_STEP_DEGREES   = 3'd3,
		REG_STEP_INTERVAL  = 3'd4,
		REG_SETTLE         = 3'd5,
		REG_MAX_DISTANCE   = 3'd6
	} cfg_reg_t;

	localparam int unsigned CFG_DATA_BITS = 10;

	// Reset values of the registers
	localparam logic       RST_SONAR_ENABLE = 1'b1;
	localparam logic       RST_AUTO_PAN = 1'b1;
	localparam logic [7:0] RST_MANUAL_ANGLE = 8'd90;
	localparam logic [7:0] RST_STEP_DEGREES = 8'd2;
	localparam logic [9:0] RST_STEP_INTERVAL = 10'd20;
	localparam logic [9:0] RST_SETTLE = 10'd140;
	localparam logic [8:0] RST_MAX_DISTANCE = 9'd200;

	typedef struct packed {
		logic       sonar_enable;
		logic       auto_pan;
		logic [7:0] manual_angle;
		logic [7:0] step_degrees;
		logic [9:0] step_interval_ms;
		logic [9:0] settle_ms;
		logic [8:0] max_distance_cm;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [7:0] pan_angle;
		logic [8:0] left_cm;
		logic [8:0] right_cm;
		logic [8:0] closest_cm;
		logic       sample_taken;
	} res_t;

	typedef struct packed {
		logic [8:0] left_cm;
		logic [8:0] right_cm;
		logic [8:0] closest_cm;
	} held_t;

	// Sector target angles: left, center, right
	function automatic logic [7:0] sector_angle(input logic [1:0] idx);
		logic [7:0] a;
		case (idx)
			2'd1:    a = 8'd90;
			2'd2:    a = 8'd160;
			default: a = 8'd20;
		endcase
		return a;
	endfunction

	// Sensor range saturated to 1..500
	function automatic logic [8:0] range_cm(input logic [8:0] m);
		logic [8:0] r;
		if (m < RANGE_MIN) begin
			r = RANGE_MIN;
		end else if (m > RANGE_MAX) begin
			r = RANGE_MAX;
		end else begin
			r = m;
		end
		return r;
	endfunction

	function automatic logic [7:0] clamp_angle(input logic [7:0] a);
		return (a > MAX_ANGLE) ? MAX_ANGLE : a;
	endfunction

	// Nearer of two echoes; no echo or out of range counts as far
	function automatic logic [8:0] combine_echo(input logic [8:0] a, input logic [8:0] b,
			input logic [8:0] far);
		logic [8:0] x;
		logic [8:0] y;
		x = (a == 9'd0 || a > far) ? far : a;
		y = (b == 9'd0 || b > far) ? far : b;
		return (x < y) ? x : y;
	endfunction

	// Reported distances, far shown as zero
	function automatic held_t held_of(input logic [8:0] d0, input logic [8:0] d1,
			input logic [8:0] d2, input logic [8:0] rng);
		held_t h;
		logic [8:0] n;
		n = d0;
		if (d1 < n) n = d1;
		if (d2 < n) n = d2;
		h.left_cm = (d0 <= rng) ? d0 : 9'd0;
		h.right_cm = (d2 <= rng) ? d2 : 9'd0;
		h.closest_cm = (n <= rng) ? n : 9'd0;
		return h;
	endfunction

endpackage

`default_nettype wire

@@ sv/sps_cfg_regs.sv @@
// Configuration register file of the sonar pan sector scanner, with a one-cycle
// scan re-initialization pulse after each valid write to a listed index. Depends on sps_pkg.
`default_nettype none

module sps_cfg_regs (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [2:0]                           cfg_index,
	input  wire  [sps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output sps_pkg::cfg_t                        cfg,
	output logic                                 reinit
);
	import sps_pkg::*;

	cfg_t cfg_q;
	logic reinit_q;
	logic wr;
	logic known;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	// Only listed register indexes take a write
	always_comb begin
		case (cfg_reg_t'(cfg_index))
			REG_SONAR_ENABLE, REG_AUTO_PAN, REG_MANUAL_ANGLE, REG_STEP_DEGREES,
			REG_STEP_INTERVAL, REG_SETTLE, REG_MAX_DISTANCE: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// Register writes; unknown indexes are dropped without a reinit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sonar_enable <= RST_SONAR_ENABLE;
			cfg_q.auto_pan <= RST_AUTO_PAN;
			cfg_q.manual_angle <= RST_MANUAL_ANGLE;
			cfg_q.step_degrees <= RST_STEP_DEGREES;
			cfg_q.step_interval_ms <= RST_STEP_INTERVAL;
			cfg_q.settle_ms <= RST_SETTLE;
			cfg_q.max_distance_cm <= RST_MAX_DISTANCE;
			reinit_q <= 1'b0;
		end else begin
			reinit_q <= wr && known;
			if (wr) begin
				case (cfg_reg_t'(cfg_index))
					REG_SONAR_ENABLE:  cfg_q.sonar_enable <= cfg_data[0];
					REG_AUTO_PAN:      cfg_q.auto_pan <= cfg_data[0];
					REG_MANUAL_ANGLE:  cfg_q.manual_angle <= cfg_data[7:0];
					REG_STEP_DEGREES:  cfg_q.step_degrees <= cfg_data[7:0];
					REG_STEP_INTERVAL: cfg_q.step_interval_ms <= cfg_data[9:0];
					REG_SETTLE:        cfg_q.settle_ms <= cfg_data[9:0];
					REG_MAX_DISTANCE:  cfg_q.max_distance_cm <= cfg_data[8:0];
					default:           ;
				endcase
			end
		end
	end

	assign cfg = cfg_q;
	assign reinit = reinit_q;

endmodule

`default_nettype wire

@@ sv/sps_scan_core.sv @@
// Scan state and single-pass update logic: pan stepping, settle wait, sector
// store and held distances. Depends on sps_pkg.
`default_nettype none

module sps_scan_core #(
	parameter int unsigned TIME_BITS = sps_pkg::TIME_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire sps_pkg::cfg_t     cfg,
	input  wire                    reinit,
	input  wire                    adv,
	input  wire  [TIME_BITS-1:0]   now,
	input  wire  [8:0]             echo_a,
	input  wire  [8:0]             echo_b,
	output sps_pkg::res_t          res
);
	import sps_pkg::*;

	// Scan state
	logic [7:0]           cur_q, tgt_q;
	logic [1:0]           idx_q;
	logic                 wait_q, stepv_q;
	logic [TIME_BITS-1:0] last_step_q, moved_q;
	logic [8:0]           sd_q [SECTOR_COUNT];

	// Next-state values
	logic [7:0]           cur_n, tgt_n;
	logic [1:0]           idx_n, idx;
	logic                 wait_n, stepv_n, taken;
	logic [TIME_BITS-1:0] last_step_n, moved_n;
	logic [8:0]           sd_n [SECTOR_COUNT];

	logic [8:0]           rng, far, echo;
	logic [7:0]           step, gap_deg, reinit_angle;
	logic [TIME_BITS-1:0] since_step, since_move;
	held_t                held;

	assign rng = range_cm(cfg.max_distance_cm);
	assign far = rng + 9'd1;
	assign echo = combine_echo(echo_a, echo_b, far);
	assign idx = (idx_q < 2'(SECTOR_COUNT)) ? idx_q : 2'd0;
	assign step = (cfg.step_degrees == 8'd0) ? 8'd1 : cfg.step_degrees;
	assign gap_deg = (tgt_q > cur_q) ? (tgt_q - cur_q) : (cur_q - tgt_q);
	assign since_step = now - last_step_q;
	assign since_move = now - moved_q;
	assign reinit_angle = (cfg.sonar_enable && !cfg.auto_pan) ?
		clamp_angle(cfg.manual_angle) : CENTER_ANGLE;

	// One pass of the scan loop
	always_comb begin
		cur_n = cur_q;
		tgt_n = tgt_q;
		idx_n = idx_q;
		wait_n = wait_q;
		stepv_n = stepv_q;
		last_step_n = last_step_q;
		moved_n = moved_q;
		taken = 1'b0;
		for (int i = 0; i < SECTOR_COUNT; i++) begin
			sd_n[i] = sd_q[i];
		end
		if (cfg.sonar_enable) begin
			if (!cfg.auto_pan) begin
				// manual mode fills the center sector every pass
				sd_n[1] = echo;
				taken = 1'b1;
			end else if (!wait_q) begin
				// pick the next target
				tgt_n = sector_angle(idx);
				if (cur_q == sector_angle(idx)) moved_n = now;
				stepv_n = 1'b0;
				wait_n = 1'b1;
			end else if (cur_q != tgt_q) begin
				// step toward target, rate limited
				if (!stepv_q || since_step >= TIME_BITS'(cfg.step_interval_ms)) begin
					if (gap_deg <= step) begin
						cur_n = tgt_q;
					end else if (tgt_q > cur_q) begin
						cur_n = cur_q + step;
					end else begin
						cur_n = cur_q - step;
					end
					last_step_n = now;
					stepv_n = 1'b1;
					moved_n = now;
				end
			end else if (since_move >= TIME_BITS'(cfg.settle_ms)) begin
				// settled: store the sector and move on
				for (int i = 0; i < SECTOR_COUNT; i++) begin
					if (idx == 2'(i)) sd_n[i] = echo;
				end
				idx_n = (idx == 2'(SECTOR_COUNT - 1)) ? 2'd0 : idx + 2'd1;
				wait_n = 1'b0;
				taken = 1'b1;
			end
		end
	end

	// Result of this pass from the updated state
	always_comb begin
		held = held_of(sd_n[0], sd_n[1], sd_n[2], rng);
		res.pan_angle = cur_n;
		res.left_cm = held.left_cm;
		res.right_cm = held.right_cm;
		res.closest_cm = held.closest_cm;
		res.sample_taken = taken;
	end

	// State registers; reinit has priority over a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= CENTER_ANGLE;
			tgt_q <= CENTER_ANGLE;
			idx_q <= 2'd0;
			wait_q <= 1'b0;
			stepv_q <= 1'b0;
			last_step_q <= '0;
			moved_q <= '0;
			for (int i = 0; i < SECTOR_COUNT; i++) begin
				sd_q[i] <= range_cm(RST_MAX_DISTANCE) + 9'd1;
			end
		end else if (reinit) begin
			cur_q <= reinit_angle;
			tgt_q <= reinit_angle;
			idx_q <= 2'd0;
			wait_q <= 1'b0;
			stepv_q <= 1'b0;
			last_step_q <= '0;
			for (int i = 0; i < SECTOR_COUNT; i++) begin
				sd_q[i] <= far;
			end
		end else if (adv) begin
			cur_q <= cur_n;
			tgt_q <= tgt_n;
			idx_q <= idx_n;
			wait_q <= wait_n;
			stepv_q <= stepv_n;
			last_step_q <= last_step_n;
			moved_q <= moved_n;
			for (int i = 0; i < SECTOR_COUNT; i++) begin
				sd_q[i] <= sd_n[i];
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/sonar_pan_sector_scanner.sv @@
// Sonar pan sector scanner: one item per cycle while out_stall is low; an accepted
// item passes the input register, then the scan update, then the result register,
// which raises out_valid. Throughput is one item per clock while out_stall is low;
// the scan update sits between the two registers.
// A write to a listed configuration register re-initializes the scan state on the following cycle.
// arst_n clears all control state and loads register and scan reset values.
`default_nettype none

module sonar_pan_sector_scanner #(
	parameter int unsigned TIME_BITS = sps_pkg::TIME_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [31:0]                         now_ms,
	input  wire  [8:0]                          echo_a_cm,
	input  wire  [8:0]                          echo_b_cm,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [7:0]                          pan_angle,
	output logic [8:0]                          left_cm,
	output logic [8:0]                          right_cm,
	output logic [8:0]                          closest_cm,
	output logic                                sample_taken,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [2:0]                          cfg_index,
	input  wire  [sps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import sps_pkg::*;

	cfg_t                 cfg;
	logic                 reinit;
	logic                 valid_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [8:0]           echo_a_s1, echo_b_s1;
	logic                 out_valid_q;
	res_t                 res_n, res_q;
	logic                 out_free, adv, in_take;

	// Handshake: stage 1 moves on whenever the result register is free or drains
	assign out_free = !out_valid_q || !out_stall;
	assign adv = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take = in_valid && !in_stall;

	sps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.reinit    (reinit)
	);

	sps_scan_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.reinit (reinit),
		.adv    (adv),
		.now    (now_s1),
		.echo_a (echo_a_s1),
		.echo_b (echo_b_s1),
		.res    (res_n)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1 <= now_ms[TIME_BITS-1:0];
			echo_a_s1 <= echo_a_cm;
			echo_b_s1 <= echo_b_cm;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign pan_angle = res_q.pan_angle;
	assign left_cm = res_q.left_cm;
	assign right_cm = res_q.right_cm;
	assign closest_cm = res_q.closest_cm;
	assign sample_taken = res_q.sample_taken;

`ifndef SYNTH
	// Input side only stalls when stage 1 holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty stage 1");

	// A pass leaves the pan angle within range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pan_angle <= MAX_ANGLE)
		else $error("pan angle beyond 180");

	// Nearest distance never exceeds a known left or right distance
	a_closest_left: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && left_cm != 9'd0) |-> (closest_cm != 9'd0 && closest_cm <= left_cm))
		else $error("closest above left distance");

	a_closest_right: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && right_cm != 9'd0) |-> (closest_cm != 9'd0 && closest_cm <= right_cm))
		else $error("closest above right distance");
`endif

endmodule

`default_nettype wire
